FILE: rtl/core/rmt_pkg.sv
// shared constants, opcodes and controller/datapath command types for the trainer
package rmt_pkg;
  localparam int MaxPlayers = 3;
  localparam int ActionBits = 3;
  localparam int NaMax = 1 << ActionBits;
  localparam int AddrBits = MaxPlayers * ActionBits;
  localparam int PlayerBits = 2;
  localparam int StoreBits = PlayerBits + ActionBits;
  localparam int TableBits = PlayerBits + AddrBits;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_ITER = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [0:0] CFG_PLAYERS = 1'd0;
  localparam logic [0:0] CFG_ACTIONS = 1'd1;

  // datapath micro-operations
  localparam logic [3:0] DP_NOP = 4'd0;
  localparam logic [3:0] DP_CAPTURE = 4'd1;
  localparam logic [3:0] DP_LOAD = 4'd2;
  localparam logic [3:0] DP_READ = 4'd3;
  localparam logic [3:0] DP_TOTAL = 4'd4;
  localparam logic [3:0] DP_DIV_START = 4'd5;
  localparam logic [3:0] DP_DIV_STEP = 4'd6;
  localparam logic [3:0] DP_STRAT = 4'd7;
  localparam logic [3:0] DP_PICK = 4'd8;
  localparam logic [3:0] DP_BASE_RD = 4'd9;
  localparam logic [3:0] DP_BASE_LAT = 4'd10;
  localparam logic [3:0] DP_ALT_RD = 4'd11;
  localparam logic [3:0] DP_REGRET = 4'd12;
  localparam logic [3:0] DP_RESULT = 4'd13;
  localparam logic [3:0] DP_RESULT_IDLE = 4'd14;

  typedef struct packed {
    logic [3:0] op;
    logic [PlayerBits-1:0] player;
    logic [ActionBits-1:0] act;
  } rmt_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic total_zero;
    logic out_busy;
    logic [PlayerBits-1:0] np_last;
    logic [ActionBits-1:0] na_last;
  } rmt_status_t;
endpackage

FILE: rtl/core/rmt_datapath.sv
// datapath: stores, payout table, serial divider, sampler and result register
module rmt_datapath import rmt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  rmt_cmd_t cmd,
  output rmt_status_t status,
  input  logic cfg_valid,
  input  logic cfg_index,
  input  logic [3:0] cfg_data,
  input  logic in_take,
  input  logic [1:0] action,
  input  logic [1:0] player_sel,
  input  logic [8:0] payout_address,
  input  logic signed [15:0] payout_value,
  input  logic [15:0] rand_p0,
  input  logic [15:0] rand_p1,
  input  logic [15:0] rand_p2,
  input  logic [2:0] read_index,
  output logic out_valid,
  input  logic out_ready,
  output logic [2:0] chosen_p0,
  output logic [2:0] chosen_p1,
  output logic [2:0] chosen_p2,
  output logic [31:0] regret_value,
  output logic [31:0] strategy_sum
);
  localparam int Slots = MaxPlayers * NaMax;
  localparam int Profiles = 1 << AddrBits;

  logic [1:0] num_players;
  logic [3:0] num_actions;
  logic [1:0] op_r;
  logic [PlayerBits-1:0] sel_r;
  logic [AddrBits-1:0] addr_r;
  logic [15:0] pval_r;
  logic [15:0] rnd_r [MaxPlayers];
  logic [ActionBits-1:0] ridx_r;

  logic [31:0] regret [Slots];
  logic [31:0] strat [Slots];
  logic [15:0] ptable [MaxPlayers * Profiles];
  logic [15:0] prd;
  logic [TableBits-1:0] prd_addr;

  logic [34:0] total;
  logic [47:0] quot;
  logic [34:0] rem;
  logic [16:0] prob;
  logic [16:0] cum;
  logic found;
  logic [ActionBits-1:0] pick;
  logic [ActionBits-1:0] chosen [MaxPlayers];
  logic signed [15:0] base;

  logic [1:0] np_c;
  logic [3:0] na_c;
  logic [StoreBits-1:0] slot;
  logic [AddrBits-1:0] profile;
  logic [AddrBits-1:0] alt;
  logic [35:0] rem_sh;
  logic [32:0] ssum;
  logic signed [34:0] rsum;
  logic [16:0] uni_prob;
  logic is_iter;
  logic rd_ok;
  logic [StoreBits-1:0] rd_slot;

  assign np_c = (num_players < 2'd2) ? 2'd2 : num_players;
  assign na_c = (num_actions < 4'd2) ? 4'd2 : (num_actions > 4'(NaMax)) ? 4'(NaMax)
              : num_actions;
  assign slot = StoreBits'(cmd.player * NaMax + cmd.act);

  // uniform share of 1.0 for each clamped action count
  always_comb begin
    case (na_c)
      4'd2: uni_prob = 17'd32768;
      4'd3: uni_prob = 17'd21845;
      4'd4: uni_prob = 17'd16384;
      4'd5: uni_prob = 17'd13107;
      4'd6: uni_prob = 17'd10922;
      4'd7: uni_prob = 17'd9362;
      default: uni_prob = 17'd8192;
    endcase
  end

  assign is_iter = (op_r == OP_ITER);
  assign rd_ok = (op_r == OP_READ) && (sel_r < 2'(MaxPlayers));
  assign rd_slot = StoreBits'(sel_r * NaMax + ridx_r);

  always_comb begin
    profile = '0;
    for (int p = 0; p < MaxPlayers; p++)
      profile[p*ActionBits +: ActionBits] = chosen[p];
    alt = profile;
    alt[cmd.player*ActionBits +: ActionBits] = cmd.act;
  end

  assign rem_sh = {rem, 1'b0} | 36'(quot[47]);
  assign ssum = {1'b0, strat[slot]} + 33'(prob);
  assign rsum = $signed({3'b000, regret[slot]}) + 35'($signed(prd)) - 35'(base);

  assign status.opcode = op_r;
  assign status.total_zero = (total == '0);
  assign status.out_busy = out_valid;
  assign status.np_last = PlayerBits'(np_c - 2'd1);
  assign status.na_last = ActionBits'(na_c - 4'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_players <= 2'd2;
      num_actions <= 4'd8;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_PLAYERS) num_players <= cfg_data[1:0];
      else num_actions <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r <= action;
      sel_r <= player_sel;
      addr_r <= payout_address;
      pval_r <= payout_value;
      rnd_r[0] <= rand_p0;
      rnd_r[1] <= rand_p1;
      rnd_r[2] <= rand_p2;
      ridx_r <= read_index;
    end
  end

  // payout table: one registered read a cycle, plus one write on a load command
  always_comb begin
    prd_addr = TableBits'(cmd.player * Profiles + alt);
    if (cmd.op == DP_BASE_RD) prd_addr = TableBits'(cmd.player * Profiles + profile);
  end
  always_ff @(posedge clk) begin
    if (cmd.op == DP_LOAD && sel_r < 2'(MaxPlayers))
      ptable[TableBits'(sel_r * Profiles + addr_r)] <= pval_r;
    prd <= ptable[prd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Slots; i++) begin
        regret[i] <= '0;
        strat[i] <= '0;
      end
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (cmd.op)
        DP_CAPTURE: begin
          for (int p = 0; p < MaxPlayers; p++) chosen[p] <= '0;
        end
        DP_TOTAL: begin
          if (cmd.act == '0) total <= 35'(regret[slot]);
          else total <= total + 35'(regret[slot]);
          cum <= '0;
          found <= 1'b0;
        end
        DP_DIV_START: begin
          quot <= {regret[slot], 16'd0};
          rem <= '0;
        end
        DP_DIV_STEP: begin
          // one restoring division bit a cycle
          if (rem_sh >= {1'b0, total}) begin
            rem <= 35'(rem_sh - {1'b0, total});
            quot <= {quot[46:0], 1'b1};
          end else begin
            rem <= rem_sh[34:0];
            quot <= {quot[46:0], 1'b0};
          end
        end
        DP_STRAT: begin
          if (status.total_zero) prob <= uni_prob;
          else prob <= quot[16:0];
        end
        DP_PICK: begin
          strat[slot] <= ssum[32] ? 32'hFFFF_FFFF : ssum[31:0];
          cum <= cum + prob;
          if (!found && {1'b0, rnd_r[cmd.player]} < 17'(cum + prob)) begin
            found <= 1'b1;
            pick <= cmd.act;
          end
          if (cmd.act == status.na_last)
            chosen[cmd.player] <= (found || {1'b0, rnd_r[cmd.player]} < 17'(cum + prob))
                                  ? ((found) ? pick : cmd.act) : status.na_last;
        end
        DP_BASE_LAT: base <= prd;
        DP_REGRET: begin
          if (rsum < 0) regret[slot] <= '0;
          else if (rsum[34:32] != 3'd0) regret[slot] <= 32'hFFFF_FFFF;
          else regret[slot] <= rsum[31:0];
        end
        DP_RESULT, DP_RESULT_IDLE: begin
          out_valid <= 1'b1;
          chosen_p0 <= is_iter ? chosen[0] : '0;
          chosen_p1 <= is_iter ? chosen[1] : '0;
          chosen_p2 <= is_iter ? chosen[2] : '0;
          regret_value <= rd_ok ? regret[rd_slot] : '0;
          strategy_sum <= rd_ok ? strat[rd_slot] : '0;
        end
        default: ;
      endcase
    end
  end
endmodule

FILE: rtl/core/rmt_control.sv
// controller: sequences load, read and the per-player training walk
module rmt_control import rmt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  rmt_status_t status,
  output rmt_cmd_t cmd
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_TOTAL = 4'd2;
  localparam logic [3:0] S_DSTART = 4'd3;
  localparam logic [3:0] S_DSTEP = 4'd4;
  localparam logic [3:0] S_STRAT = 4'd5;
  localparam logic [3:0] S_PICK = 4'd6;
  localparam logic [3:0] S_BRD = 4'd7;
  localparam logic [3:0] S_BLAT = 4'd8;
  localparam logic [3:0] S_ARD = 4'd9;
  localparam logic [3:0] S_REG = 4'd10;
  localparam logic [3:0] S_OUT = 4'd11;

  logic [3:0] state, state_next;
  logic [PlayerBits-1:0] pl, pl_next;
  logic [ActionBits-1:0] ac, ac_next;
  logic [5:0] cnt, cnt_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pl <= '0;
      ac <= '0;
      cnt <= '0;
    end else begin
      state <= state_next;
      pl <= pl_next;
      ac <= ac_next;
      cnt <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    pl_next = pl;
    ac_next = ac;
    cnt_next = cnt;
    cmd.op = DP_NOP;
    cmd.player = pl;
    cmd.act = ac;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        pl_next = '0;
        ac_next = '0;
        cmd.op = DP_CAPTURE;
        if (status.opcode == OP_ITER) state_next = S_TOTAL;
        else begin
          if (status.opcode == OP_LOAD) cmd.op = DP_LOAD;
          state_next = S_OUT;
        end
      end
      S_TOTAL: begin
        cmd.op = DP_TOTAL;
        if (ac == status.na_last) begin
          ac_next = '0;
          state_next = S_DSTART;
        end else ac_next = ac + 1'b1;
      end
      S_DSTART: begin
        cmd.op = DP_DIV_START;
        cnt_next = '0;
        state_next = status.total_zero ? S_STRAT : S_DSTEP;
      end
      S_DSTEP: begin
        cmd.op = DP_DIV_STEP;
        cnt_next = cnt + 1'b1;
        if (cnt == 6'd47) state_next = S_STRAT;
      end
      S_STRAT: begin
        cmd.op = DP_STRAT;
        state_next = S_PICK;
      end
      S_PICK: begin
        cmd.op = DP_PICK;
        if (ac == status.na_last) begin
          ac_next = '0;
          if (pl == status.np_last) begin
            pl_next = '0;
            state_next = S_BRD;
          end else begin
            pl_next = pl + 1'b1;
            state_next = S_TOTAL;
          end
        end else begin
          ac_next = ac + 1'b1;
          state_next = S_DSTART;
        end
      end
      S_BRD: begin
        cmd.op = DP_BASE_RD;
        state_next = S_BLAT;
      end
      S_BLAT: begin
        cmd.op = DP_BASE_LAT;
        state_next = S_ARD;
      end
      S_ARD: begin
        cmd.op = DP_ALT_RD;
        state_next = S_REG;
      end
      S_REG: begin
        cmd.op = DP_REGRET;
        if (ac == status.na_last) begin
          ac_next = '0;
          if (pl == status.np_last) state_next = S_OUT;
          else begin
            pl_next = pl + 1'b1;
            state_next = S_BRD;
          end
        end else begin
          ac_next = ac + 1'b1;
          state_next = S_ARD;
        end
      end
      S_OUT: begin
        if (!status.out_busy) begin
          cmd.op = DP_RESULT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

FILE: rtl/core/regret_matching_trainer.sv
// Regret-matching trainer: one item in, one result out. Load and read items
// go from idle through decode to the result state, which waits while an
// earlier result is still unaccepted. An iterate item walks every active
// player's actions three times: a summing pass, then per action a restoring
// divider between its start, strategy and pick steps (the division steps
// skipped while the regret total is zero), then a regret pass through the
// payout table's registered read, reading each player's base payout once.
// Regrets in the updated pass use the regret store as it stands, other players' sums
// already final. Input is taken only while the controller is idle.
module regret_matching_trainer import rmt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] action,
  input  logic [1:0] player_sel,
  input  logic [8:0] payout_address,
  input  logic signed [15:0] payout_value,
  input  logic [15:0] rand_p0,
  input  logic [15:0] rand_p1,
  input  logic [15:0] rand_p2,
  input  logic [2:0] read_index,
  output logic out_valid,
  input  logic out_ready,
  output logic [2:0] chosen_p0,
  output logic [2:0] chosen_p1,
  output logic [2:0] chosen_p2,
  output logic [31:0] regret_value,
  output logic [31:0] strategy_sum,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_index,
  input  logic [3:0] cfg_data
);
  rmt_cmd_t cmd;
  rmt_status_t status;

  assign cfg_ready = 1'b1;

  rmt_control u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .status, .cmd
  );

  rmt_datapath u_dp (
    .clk, .rst, .cmd, .status, .cfg_valid, .cfg_index, .cfg_data,
    .in_take(in_valid && in_ready), .action, .player_sel, .payout_address,
    .payout_value, .rand_p0, .rand_p1, .rand_p2, .read_index,
    .out_valid, .out_ready, .chosen_p0, .chosen_p1, .chosen_p2,
    .regret_value, .strategy_sum
  );

  a_busy_no_take: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("second beat taken");
  a_zero_on_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && status.opcode == OP_LOAD |-> regret_value == '0)
    else $error("load result not zero");
endmodule

FILE: tb/sv/rmt_checker.sv
// checker for the regret-matching trainer: watches the channels, predicts each result and compares
module rmt_checker import rmt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  action,
  input  logic [1:0]  player_sel,
  input  logic [8:0]  payout_address,
  input  logic [15:0] payout_value,
  input  logic [15:0] rand_p0,
  input  logic [15:0] rand_p1,
  input  logic [15:0] rand_p2,
  input  logic [2:0]  read_index,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  chosen_p0,
  input  logic [2:0]  chosen_p1,
  input  logic [2:0]  chosen_p2,
  input  logic [31:0] regret_value,
  input  logic [31:0] strategy_sum,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data,
  output int          errors,
  output int          pending,
  output int          iterations
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  c0;
    logic [2:0]  c1;
    logic [2:0]  c2;
    logic [31:0] regret;
    logic [31:0] strat;
  } outcome_t;

  logic [15:0] payoff_mem [MaxPlayers * 512];
  logic [31:0] regret_mem [MaxPlayers * NaMax];
  logic [31:0] strat_mem [MaxPlayers * NaMax];
  logic [1:0]  players_reg;
  logic [3:0]  actions_reg;
  outcome_t    pending_outcomes [$];

  function automatic int payoff(int p, int prof);
    return int'($signed(payoff_mem[p * 512 + prof]));
  endfunction

  task automatic train_step(output outcome_t e);
    int np, na, profile, base, sh, alt;
    int chosen [MaxPlayers];
    longint unsigned total, cum, s;
    longint v;
    logic [31:0] prob [NaMax];
    logic [15:0] rnd [MaxPlayers];
    int pick;
    bit found;
    e = '0;
    np = players_reg < 2 ? 2 : (players_reg > MaxPlayers ? MaxPlayers : players_reg);
    na = actions_reg < 2 ? 2 : (actions_reg > NaMax ? NaMax : actions_reg);
    rnd[0] = rand_p0;
    rnd[1] = rand_p1;
    rnd[2] = rand_p2;
    case (action)
      OP_LOAD: if (player_sel < MaxPlayers)
        payoff_mem[player_sel * 512 + payout_address] = payout_value;
      OP_READ: if (player_sel < MaxPlayers) begin
        e.regret = regret_mem[player_sel * NaMax + read_index];
        e.strat = strat_mem[player_sel * NaMax + read_index];
      end
      OP_ITER: begin
        profile = 0;
        for (int p = 0; p < MaxPlayers; p++) chosen[p] = 0;
        for (int p = 0; p < np; p++) begin
          total = 0;
          cum = 0;
          pick = na - 1;
          found = 0;
          for (int a = 0; a < na; a++) total += regret_mem[p * NaMax + a];
          for (int a = 0; a < na; a++)
            if (total == 0) prob[a] = 32'(65536 / na);
            else prob[a] = 32'((longint'(regret_mem[p * NaMax + a]) * 65536) / total);
          for (int a = 0; a < na; a++) begin
            s = longint'(strat_mem[p * NaMax + a]) + prob[a];
            strat_mem[p * NaMax + a] = s > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : s[31:0];
            cum += prob[a];
            if (!found && longint'(rnd[p]) < cum) begin
              pick = a;
              found = 1;
            end
          end
          chosen[p] = pick;
          profile |= pick << (ActionBits * p);
        end
        // each player's regrets use only its own entries and the fixed profile
        for (int p = 0; p < np; p++) begin
          base = payoff(p, profile);
          sh = ActionBits * p;
          for (int a = 0; a < na; a++) begin
            alt = (profile & ~(7 << sh)) | (a << sh);
            v = longint'(regret_mem[p * NaMax + a]) + longint'(payoff(p, alt) - base);
            if (v < 0) v = 0;
            if (v > 64'sh0FFFF_FFFF) v = 64'sh0FFFF_FFFF;
            regret_mem[p * NaMax + a] = v[31:0];
          end
        end
        e.c0 = 3'(chosen[0]);
        e.c1 = 3'(chosen[1]);
        e.c2 = 3'(chosen[2]);
        iterations++;
      end
      default: ;
    endcase
  endtask

  assign pending = pending_outcomes.size();

  always @(posedge clk) begin
    outcome_t e;
    if (rst) begin
      foreach (payoff_mem[i]) payoff_mem[i] = '0;
      foreach (regret_mem[i]) regret_mem[i] = '0;
      foreach (strat_mem[i]) strat_mem[i] = '0;
      players_reg = 2'd2;
      actions_reg = 4'd8;
      pending_outcomes.delete();
      errors = 0;
      iterations = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PLAYERS) players_reg = cfg_data[1:0];
        else actions_reg = cfg_data;
      end
      // compare before pushing: a result never belongs to the beat taken at the same edge
      if (out_valid && out_ready) begin
        if (pending_outcomes.size() == 0) begin
          $display("%0t: result beat with nothing expected", $time);
          errors++;
        end else begin
          e = pending_outcomes.pop_front();
          if (chosen_p0 !== e.c0) begin
            $display("%0t: chosen_p0 exp %0d got %0d", $time, e.c0, chosen_p0);
            errors++;
          end
          if (chosen_p1 !== e.c1) begin
            $display("%0t: chosen_p1 exp %0d got %0d", $time, e.c1, chosen_p1);
            errors++;
          end
          if (chosen_p2 !== e.c2) begin
            $display("%0t: chosen_p2 exp %0d got %0d", $time, e.c2, chosen_p2);
            errors++;
          end
          if (regret_value !== e.regret) begin
            $display("%0t: regret_value exp %h got %h", $time, e.regret, regret_value);
            errors++;
          end
          if (strategy_sum !== e.strat) begin
            $display("%0t: strategy_sum exp %h got %h", $time, e.strat, strategy_sum);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        train_step(e);
        pending_outcomes = {pending_outcomes, e};
      end
    end
  end
endmodule

FILE: tb/sv/testbench.sv
// top of the trainer testbench: clock, reset, stimulus, watchdog and verdict
module testbench;
  import rmt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [1:0] action, player_sel;
  logic [8:0] payout_address;
  logic signed [15:0] payout_value;
  logic [15:0] rand_p0, rand_p1, rand_p2;
  logic [2:0] read_index, chosen_p0, chosen_p1, chosen_p2;
  logic [31:0] regret_value, strategy_sum;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [3:0] cfg_data;
  int errors, pending, iterations;
  int cycle_count, quiet_cycles;
  bit sender_idles;
  bit written [MaxPlayers][512];

  regret_matching_trainer u_top (.*);

  rmt_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst <= 1;
    in_valid <= 0;
    out_ready <= 0;
    cfg_valid <= 0;
    cfg_index <= CFG_PLAYERS;
    cfg_data <= '0;
    action <= OP_LOAD;
    player_sel <= '0;
    payout_address <= '0;
    payout_value <= '0;
    rand_p0 <= '0;
    rand_p1 <= '0;
    rand_p2 <= '0;
    read_index <= '0;
    repeat (7) @(posedge clk);
    rst <= 0;
  end

  // receiver: random stalls, one long hold-off and one stretch always ready
  always @(posedge clk) begin
    if (rst) cycle_count <= 0;
    else cycle_count <= cycle_count + 1;
    if (rst) out_ready <= 0;
    else if (cycle_count >= 20000 && cycle_count < 23000) out_ready <= 0;
    else if (cycle_count >= 60000 && cycle_count < 90000) out_ready <= 1;
    else out_ready <= $urandom_range(99) >= 37;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 20000) begin
      $display("watchdog: no beat for %0d cycles", quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send(logic [1:0] op, logic [1:0] sel, logic [8:0] addr, logic [15:0] val,
                      logic [15:0] r0, logic [15:0] r1, logic [15:0] r2, logic [2:0] ridx);
    while (sender_idles && $urandom_range(99) < 37) begin
      in_valid <= 0;
      @(posedge clk);
    end
    action <= op;
    player_sel <= sel;
    payout_address <= addr;
    payout_value <= val;
    rand_p0 <= r0;
    rand_p1 <= r1;
    rand_p2 <= r2;
    read_index <= ridx;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == OP_LOAD && sel < MaxPlayers) written[sel][addr] = 1;
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [3:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  function automatic logic [8:0] profile_of(int code, int np, int na);
    logic [8:0] prof;
    prof = '0;
    for (int k = 0; k < np; k++) begin
      prof |= 9'(code % na) << (ActionBits * k);
      code /= na;
    end
    return prof;
  endfunction

  // every profile an iteration can touch must hold a payoff first
  task automatic fill_table(int np, int na);
    int n;
    logic [8:0] prof;
    n = 1;
    for (int k = 0; k < np; k++) n *= na;
    for (int p = 0; p < np; p++)
      for (int c = 0; c < n; c++) begin
        prof = profile_of(c, np, na);
        if (!written[p][prof])
          send(OP_LOAD, 2'(p), prof, 16'($urandom), 0, 0, 0, 0);
      end
  endtask

  task automatic random_item(int np, int na);
    int pick;
    logic [8:0] addr;
    pick = $urandom_range(99);
    if (pick < 40)
      send(OP_ITER, 2'($urandom), 9'($urandom), 16'($urandom),
           16'($urandom), 16'($urandom), 16'($urandom), 3'($urandom));
    else if (pick < 65) begin
      if ($urandom_range(1)) addr = profile_of($urandom, np, na);
      else addr = 9'($urandom);
      send(OP_LOAD, 2'($urandom_range(MaxPlayers - 1)), addr, 16'($urandom),
           16'($urandom), 16'($urandom), 16'($urandom), 3'($urandom));
    end else if (pick < 92)
      send(OP_READ, 2'($urandom), 9'($urandom), 16'($urandom),
           16'($urandom), 16'($urandom), 16'($urandom), 3'($urandom));
    else if (pick < 96)
      send(2'd3, 2'($urandom), 9'($urandom), 16'($urandom),
           16'($urandom), 16'($urandom), 16'($urandom), 3'($urandom));
    else
      send(OP_LOAD, 2'd3, 9'($urandom), 16'($urandom), 0, 0, 0, 3'($urandom));
  endtask

  initial begin
    int np_raw [7] = '{2, 3, 0, 3, 1, 2, 3};
    int na_raw [7] = '{8, 2, 1, 3, 15, 4, 4};
    int np, na;
    sender_idles = 1;
    @(negedge rst);
    @(posedge clk);
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(CFG_PLAYERS, 4'(np_raw[ph]));
      write_reg(CFG_ACTIONS, 4'(na_raw[ph]));
      np = np_raw[ph] < 2 ? 2 : np_raw[ph];
      na = na_raw[ph] < 2 ? 2 : (na_raw[ph] > NaMax ? NaMax : na_raw[ph]);
      sender_idles = (ph != 3);
      fill_table(np, na);
      if (ph == 0) begin
        // first iterate sees all regrets zero, so strategies are uniform
        send(OP_ITER, 0, 0, 0, 16'h0000, 16'h0000, 16'h0000, 0);
        send(OP_READ, 0, 0, 0, 0, 0, 0, 3'd0);
        send(OP_LOAD, 0, 9'd0, 16'sh8000, 0, 0, 0, 0);
        send(OP_LOAD, 1, 9'd0, 16'sh7FFF, 0, 0, 0, 0);
        send(OP_LOAD, 0, 9'd7, 16'sh7FFF, 0, 0, 0, 0);
        send(OP_LOAD, 1, 9'd56, 16'sh8000, 0, 0, 0, 0);
        send(OP_ITER, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
        send(OP_ITER, 0, 0, 0, 16'h0000, 16'h8000, 16'hFFFF, 0);
        send(OP_LOAD, 2'd3, 9'h1FF, 16'hFFFF, 0, 0, 0, 0);
        send(OP_READ, 2'd3, 9'h1FF, 0, 0, 0, 0, 3'd7);
        send(2'd3, 2'd1, 9'h1FF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7);
        for (int i = 0; i < 8; i++) send(OP_READ, 0, 0, 0, 0, 0, 0, 3'(i));
        send(OP_READ, 1, 0, 0, 0, 0, 0, 3'd7);
        send(OP_READ, 2, 0, 0, 0, 0, 0, 3'd7);
      end
      for (int i = 0; i < 150; i++) random_item(np, na);
      drain();
    end
    $display("covered %0d iterations over seven register settings, with loads, reads,",
             iterations);
    $display("no-ops, ignored player selects, random stalls and one long output hold-off");
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
